// ----- sv/fce_pkg.sv -----
// ----------------------------------------------------------------------------
// fce_pkg
// Types and constants shared by the feedback comb echo block.
// ----------------------------------------------------------------------------
package fce_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 15;
    localparam int DELAY_W  = 12;
    localparam int ENTRY_W  = 18;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 15;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LEN     = 2'd2;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 15'd16384;
    localparam logic [GAIN_W-1:0]  WET_RESET   = 15'd9830;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 12'd2205;
    localparam logic [DELAY_W-1:0] DELAY_MAX   = 12'd4095;

    localparam logic [MUL_B_W-1:0] Q15_ONE = 17'd32768;

    localparam logic signed [ENTRY_W-1:0]  ENTRY_MAX  = 18'sd131071;
    localparam logic signed [ENTRY_W-1:0]  ENTRY_MIN  = -18'sd131072;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd32768;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_FB,
        S_MUL_DRY,
        S_MUL_WET,
        S_FIN
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_store_ctrl;

endpackage

// ----- sv/feedback_comb_echo_top.sv -----
// ----------------------------------------------------------------------------
// feedback_comb_echo_top
// Feedback comb echo: delay line with Q15 feedback and wet/dry mix.
//
//   channel   direction  handshake               payload
//   input     in         i_in_valid/o_in_stall   i_sample_in
//   output    out        o_out_valid/i_out_stall o_sample_out
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Each item goes through these steps: memory read, then three passes through the one
// shared multiplier (feedback, dry, wet) and a final add and saturate.
// Store contents read as zero until written, tracked by the write pointer
// and a wrap flag, so reset needs no clearing pass.
// After reset or a delay_len write the modulo unit runs while input and
// config are held off. A stalled output holds the final step.
// ----------------------------------------------------------------------------
module feedback_comb_echo_top #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [fce_pkg::SAMPLE_W-1:0]    i_sample_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [fce_pkg::SAMPLE_W-1:0]    o_sample_out,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [fce_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [fce_pkg::CFG_DAT_W-1:0]          i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);

    fce_pkg::t_state r_state, n_state;

    logic [fce_pkg::GAIN_W-1:0] r_gain;
    logic [fce_pkg::GAIN_W-1:0] r_wet;

    logic [AW-1:0] r_wp;
    logic          r_wrapped;
    logic          r_ent_ok;

    logic signed [fce_pkg::SAMPLE_W-1:0] r_x;
    logic signed [fce_pkg::ENTRY_W-1:0]  r_del;
    logic signed [fce_pkg::SAMPLE_W-1:0] r_dry;
    logic signed [fce_pkg::SAMPLE_W-1:0] r_out;
    logic                                r_out_valid;

    logic                  mod_busy;
    logic [AW-1:0]         back;
    logic                  cfg_we;
    logic                  in_acc;
    logic                  out_free;
    logic [AW:0]           rd_diff;
    logic [AW-1:0]         rd_addr;
    logic                  rd_ok;

    fce_pkg::t_store_ctrl                 store_ctrl;
    logic signed [fce_pkg::ENTRY_W-1:0]   rd_data;
    logic signed [fce_pkg::ENTRY_W-1:0]   wr_data;
    logic signed [fce_pkg::MUL_A_W-1:0]   mul_a;
    logic signed [fce_pkg::MUL_B_W-1:0]   mul_b;
    logic signed [fce_pkg::MUL_P_W-1:0]   prod;
    logic signed [fce_pkg::ENTRY_W-1:0]   prod_q15;
    logic signed [fce_pkg::ENTRY_W:0]     fb_sum;
    logic signed [fce_pkg::ENTRY_W:0]     mix_sum;
    logic signed [fce_pkg::SAMPLE_W-1:0]  mix_sat;
    logic                                 adv_wp;
    logic                                 ld_out;

    assign o_cfg_ready = !mod_busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != fce_pkg::S_IDLE) || mod_busy;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    fce_mod #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (cfg_we && (i_cfg_index == fce_pkg::REG_DELAY_LEN)),
        .i_load_val (i_cfg_data[fce_pkg::DELAY_W-1:0]),
        .o_busy     (mod_busy),
        .o_back     (back)
    );

    // read address = (wp - back) mod depth
    assign rd_diff = {1'b0, r_wp} - {1'b0, back};
    always_comb begin
        if (rd_diff[AW]) begin
            rd_addr = AW'(rd_diff + (AW + 1)'(STORE_DEPTH));
        end else begin
            rd_addr = rd_diff[AW-1:0];
        end
    end
    assign rd_ok = r_wrapped || (rd_addr < r_wp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= fce_pkg::GAIN_RESET;
            r_wet  <= fce_pkg::WET_RESET;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                fce_pkg::REG_FEEDBACK_GAIN: r_gain <= i_cfg_data[fce_pkg::GAIN_W-1:0];
                fce_pkg::REG_WET_MIX:       r_wet  <= i_cfg_data[fce_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fce_pkg::S_IDLE:    if (in_acc) n_state = fce_pkg::S_MUL_FB;
            fce_pkg::S_MUL_FB:  n_state = fce_pkg::S_MUL_DRY;
            fce_pkg::S_MUL_DRY: n_state = fce_pkg::S_MUL_WET;
            fce_pkg::S_MUL_WET: n_state = fce_pkg::S_FIN;
            fce_pkg::S_FIN:     if (out_free) n_state = fce_pkg::S_IDLE;
            default:            n_state = fce_pkg::S_IDLE;
        endcase
    end

    // per-state controls and multiplier operands
    always_comb begin
        store_ctrl = '0;
        adv_wp     = 1'b0;
        ld_out     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (r_state)
            fce_pkg::S_IDLE: begin
                store_ctrl.rd_en = in_acc;
            end
            fce_pkg::S_MUL_FB: begin
                mul_a = r_ent_ok ? rd_data : '0;
                mul_b = fce_pkg::MUL_B_W'(r_gain);
            end
            fce_pkg::S_MUL_DRY: begin
                store_ctrl.wr_en = 1'b1;
                adv_wp = 1'b1;
                mul_a  = fce_pkg::MUL_A_W'(r_x);
                mul_b  = fce_pkg::Q15_ONE - fce_pkg::MUL_B_W'(r_wet);
            end
            fce_pkg::S_MUL_WET: begin
                mul_a = r_del;
                mul_b = fce_pkg::MUL_B_W'(r_wet);
            end
            fce_pkg::S_FIN: begin
                // same operands keep the wet product steady while stalled
                mul_a  = r_del;
                mul_b  = fce_pkg::MUL_B_W'(r_wet);
                ld_out = out_free;
            end
            default: ;
        endcase
    end

    fce_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign prod_q15 = prod[fce_pkg::ENTRY_W+14:15];

    assign fb_sum = (fce_pkg::ENTRY_W + 1)'(r_x) + (fce_pkg::ENTRY_W + 1)'(prod_q15);
    always_comb begin
        if (fb_sum > fce_pkg::ENTRY_MAX) begin
            wr_data = fce_pkg::ENTRY_MAX;
        end else if (fb_sum < fce_pkg::ENTRY_MIN) begin
            wr_data = fce_pkg::ENTRY_MIN;
        end else begin
            wr_data = fb_sum[fce_pkg::ENTRY_W-1:0];
        end
    end

    assign mix_sum = (fce_pkg::ENTRY_W + 1)'(r_dry) + (fce_pkg::ENTRY_W + 1)'(prod_q15);
    always_comb begin
        if (mix_sum > fce_pkg::SAMPLE_MAX) begin
            mix_sat = fce_pkg::SAMPLE_MAX;
        end else if (mix_sum < fce_pkg::SAMPLE_MIN) begin
            mix_sat = fce_pkg::SAMPLE_MIN;
        end else begin
            mix_sat = mix_sum[fce_pkg::SAMPLE_W-1:0];
        end
    end

    fce_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctrl    (store_ctrl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (r_wp),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fce_pkg::S_IDLE;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv_wp) begin
                if (r_wp == AW'(STORE_DEPTH - 1)) begin
                    r_wp      <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wp <= r_wp + AW'(1);
                end
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x      <= i_sample_in;
            r_ent_ok <= rd_ok;
        end
        if (r_state == fce_pkg::S_MUL_DRY) begin
            r_del <= prod_q15;
        end
        if (r_state == fce_pkg::S_MUL_WET) begin
            r_dry <= prod[fce_pkg::SAMPLE_W+14:15];
        end
        if (ld_out) begin
            r_out <= mix_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

endmodule

// ----- sv/fce_mul.sv -----
// ----------------------------------------------------------------------------
// fce_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fce_mul (
    input  logic                                  i_clk,
    input  logic signed [fce_pkg::MUL_A_W-1:0]    i_a,
    input  logic signed [fce_pkg::MUL_B_W-1:0]    i_b,
    output logic signed [fce_pkg::MUL_P_W-1:0]    o_p
);

    logic signed [fce_pkg::MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- sv/fce_store.sv -----
// ----------------------------------------------------------------------------
// fce_store
// Delay line memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fce_store #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                                i_clk,
    input  fce_pkg::t_store_ctrl                i_ctrl,
    input  logic [$clog2(STORE_DEPTH)-1:0]      i_rd_addr,
    input  logic [$clog2(STORE_DEPTH)-1:0]      i_wr_addr,
    input  logic signed [fce_pkg::ENTRY_W-1:0]  i_wr_data,
    output logic signed [fce_pkg::ENTRY_W-1:0]  o_rd_data
);

    logic signed [fce_pkg::ENTRY_W-1:0] r_mem [STORE_DEPTH];
    logic signed [fce_pkg::ENTRY_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

// ----- sv/fce_mod.sv -----
// ----------------------------------------------------------------------------
// fce_mod
// Reduces delay_len modulo the store depth, one compare-subtract per cycle.
// ----------------------------------------------------------------------------
module fce_mod #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic [fce_pkg::DELAY_W-1:0]          i_load_val,
    output logic                                 o_busy,
    output logic [$clog2(STORE_DEPTH)-1:0]       o_back
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int VW = (AW > fce_pkg::DELAY_W) ? AW : fce_pkg::DELAY_W;

    function automatic int steps_for(int d);
        int k;
        k = 0;
        for (int j = 0; j < fce_pkg::DELAY_W; j++) begin
            if ((d << k) <= int'(fce_pkg::DELAY_MAX)) begin
                k = k + 1;
            end
        end
        return k;
    endfunction

    localparam int K  = steps_for(STORE_DEPTH);
    localparam int KW = (K > 0) ? $clog2(K + 1) : 1;
    localparam logic [fce_pkg::DELAY_W-1:0] SUB0 =
        (K > 0) ? fce_pkg::DELAY_W'(STORE_DEPTH << (K - 1)) : '0;

    logic [fce_pkg::DELAY_W-1:0] r_val;
    logic [fce_pkg::DELAY_W-1:0] r_sub;
    logic [KW-1:0]               r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= fce_pkg::DELAY_RESET;
            r_sub <= SUB0;
            r_cnt <= KW'(K);
        end else if (i_load) begin
            r_val <= i_load_val;
            r_sub <= SUB0;
            r_cnt <= KW'(K);
        end else if (r_cnt != '0) begin
            if (r_val >= r_sub) begin
                r_val <= r_val - r_sub;
            end
            r_sub <= r_sub >> 1;
            r_cnt <= r_cnt - KW'(1);
        end
    end

    logic [VW-1:0] val_ext;
    assign val_ext = VW'(r_val);
    assign o_back  = val_ext[AW-1:0];
    assign o_busy  = (r_cnt != '0);

endmodule
